FILE: design/cdoef_pkg.sv
// ----------------------------------------------------------------------------
// cdoef_pkg - shared types for the coalescing event FIFO
// Item structs, command codes and the per-cell command broadcast by the top.
// ----------------------------------------------------------------------------
package cdoef_pkg;

   // default number of cells in the chain
   localparam int unsigned CAPACITY_DEFAULT = 8;

   // request kinds
   typedef enum logic [1:0] {
      KIND_PUSH  = 2'd0,
      KIND_POP   = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   // one stored event
   typedef struct packed {
      logic [7:0]  state;
      logic [31:0] payload;
      logic [31:0] revision;
   } entry_type;

   // input item
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  status_state;
      logic [31:0] status_payload;
      logic [31:0] revision;
   } req_type;

   // result item
   typedef struct packed {
      logic        found;
      logic [7:0]  out_state;
      logic [31:0] out_payload;
      logic [31:0] out_revision;
   } rsp_type;

   // operation broadcast to every cell
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_CLEAR,
      CELL_POP,
      CELL_COALESCE,
      CELL_APPEND,
      CELL_SHIFT_APPEND
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      entry_type   entry;
   } cell_cmd_type;

endpackage

FILE: design/cdoef_cell.sv
// ----------------------------------------------------------------------------
// cdoef_cell - one storage cell of the event chain
// Holds one event and a valid bit; cell 0 is the oldest. Shifts towards the
// head on a pop or a full-chain push, loads the pushed event when first free,
// and updates in place when it is the newest entry with a matching state.
// ----------------------------------------------------------------------------
module cdoef_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  cdoef_pkg::cell_cmd_type cmd,
   input  logic [7:0]              push_state,
   input  logic                    prev_valid,
   input  logic                    next_valid,
   input  cdoef_pkg::entry_type    next_entry,
   output logic                    valid,
   output cdoef_pkg::entry_type    entry,
   output logic                    hit
);

   logic                 valid_ff;
   logic                 valid_in;
   cdoef_pkg::entry_type entry_ff;
   cdoef_pkg::entry_type entry_in;

   // newest entry with the pushed state: valid with an empty neighbour behind it
   assign hit = valid_ff && !next_valid && (entry_ff.state == push_state);

   // next cell contents
   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      unique case (cmd.op)
         cdoef_pkg::CELL_HOLD: begin
         end
         cdoef_pkg::CELL_CLEAR: begin
            valid_in = 1'b0;
         end
         cdoef_pkg::CELL_POP: begin
            valid_in = next_valid;
            entry_in = next_entry;
         end
         cdoef_pkg::CELL_COALESCE: begin
            if (hit) begin
               entry_in = cmd.entry;
            end
         end
         cdoef_pkg::CELL_APPEND: begin
            if (!valid_ff && prev_valid) begin
               valid_in = 1'b1;
               entry_in = cmd.entry;
            end
         end
         cdoef_pkg::CELL_SHIFT_APPEND: begin
            // chain is full: drop the oldest, last cell takes the new event
            valid_in = 1'b1;
            entry_in = next_entry;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

   assign valid = valid_ff;
   assign entry = entry_ff;

endmodule

FILE: design/coalescing_drop_oldest_event_fifo_top.sv
// A pop result appears on rsp_data with rsp_valid in the cycle after the item is taken.
// Throughput: one item per cycle; busy stays low, every operation updates the cell chain
// at once, since each cell only looks at its two neighbours.
// Push and clear give no result; a pop always gives exactly one.
// Reset (synchronous): all cells empty, no result pending; contents need no clearing.
// ----------------------------------------------------------------------------
// coalescing_drop_oldest_event_fifo_top - coalescing event FIFO
// Decodes each item into a command broadcast along a chain of CAPACITY cells
// and registers the popped event from the head cell.
// ----------------------------------------------------------------------------
module coalescing_drop_oldest_event_fifo_top #(
   parameter int unsigned CAPACITY = cdoef_pkg::CAPACITY_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  cdoef_pkg::req_type req_data,
   output logic               rsp_valid,
   output cdoef_pkg::rsp_type rsp_data
);

   logic                    accept;
   logic [CAPACITY-1:0]     valid_vec;
   logic [CAPACITY-1:0]     hit_vec;
   cdoef_pkg::entry_type    entry_vec [CAPACITY];
   cdoef_pkg::cell_cmd_type cmd;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   cdoef_pkg::rsp_type      rsp_ff;
   cdoef_pkg::rsp_type      rsp_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // decode the item into a chain command
   always_comb begin
      cmd.entry.state    = req_data.status_state;
      cmd.entry.payload  = req_data.status_payload;
      cmd.entry.revision = req_data.revision;
      cmd.op             = cdoef_pkg::CELL_HOLD;
      if (accept) begin
         unique case (cdoef_pkg::kind_type'(req_data.kind))
            cdoef_pkg::KIND_PUSH: begin
               priority if (req_data.revision == 32'd0) begin
                  cmd.op = cdoef_pkg::CELL_HOLD;
               end else if (|hit_vec) begin
                  cmd.op = cdoef_pkg::CELL_COALESCE;
               end else if (valid_vec[CAPACITY-1]) begin
                  cmd.op = cdoef_pkg::CELL_SHIFT_APPEND;
               end else begin
                  cmd.op = cdoef_pkg::CELL_APPEND;
               end
            end
            cdoef_pkg::KIND_POP:   cmd.op = cdoef_pkg::CELL_POP;
            cdoef_pkg::KIND_CLEAR: cmd.op = cdoef_pkg::CELL_CLEAR;
            cdoef_pkg::KIND_NONE:  cmd.op = cdoef_pkg::CELL_HOLD;
            default:               cmd.op = cdoef_pkg::CELL_HOLD;
         endcase
      end
   end

   // cell chain, oldest at index 0
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                 prev_valid;
      logic                 next_valid;
      cdoef_pkg::entry_type next_entry;

      if (i == 0) begin : g_first
         assign prev_valid = 1'b1;
      end else begin : g_mid_prev
         assign prev_valid = valid_vec[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign next_valid = 1'b0;
         assign next_entry = cmd.entry;
      end else begin : g_mid_next
         assign next_valid = valid_vec[i+1];
         assign next_entry = entry_vec[i+1];
      end

      cdoef_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .push_state (req_data.status_state),
         .prev_valid (prev_valid),
         .next_valid (next_valid),
         .next_entry (next_entry),
         .valid      (valid_vec[i]),
         .entry      (entry_vec[i]),
         .hit        (hit_vec[i])
      );
   end

   // result register, taken from the head cell
   always_comb begin
      rsp_valid_in = accept && (req_data.kind == cdoef_pkg::KIND_POP);
      rsp_in.found = valid_vec[0];
      if (valid_vec[0]) begin
         rsp_in.out_state    = entry_vec[0].state;
         rsp_in.out_payload  = entry_vec[0].payload;
         rsp_in.out_revision = entry_vec[0].revision;
      end else begin
         rsp_in.out_state    = 8'd0;
         rsp_in.out_payload  = 32'd0;
         rsp_in.out_revision = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // occupied cells always form an unbroken run from the head
   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      $onehot({1'b0, valid_vec} + {{CAPACITY{1'b0}}, 1'b1}))
      else $error("cell chain has a gap");

   // a result only follows an accepted pop
   a_rsp_from_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept && (req_data.kind == cdoef_pkg::KIND_POP)))
      else $error("result without a pop");

   // a clear leaves the chain empty
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      accept && (req_data.kind == cdoef_pkg::KIND_CLEAR) |=> (valid_vec == '0))
      else $error("chain not empty after clear");

   // a pop of a non-empty chain reports found
   a_pop_found: assert property (@(posedge clock) disable iff (reset)
      accept && (req_data.kind == cdoef_pkg::KIND_POP) && valid_vec[0] |=> rsp_data.found)
      else $error("pop of stored event not found");

endmodule
